FILE: rtl/psq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the packet slot ring transmit queue.
// No dependencies; psq_ctrl and the top level refer to it by scoped names.
package psq_pkg;

    // Default geometry of the ring.
    localparam int DEF_SLOT_COUNT       = 8;
    localparam int DEF_MAX_PACKET_BYTES = 512;

    // Operation codes carried by an input transaction.
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_DONE = 2'd1,
        OP_POLL = 2'd2,
        OP_READ = 2'd3
    } t_op;

    // Status codes returned with each result.
    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_ENQ    = 2'd1,
        ST_DROP   = 2'd2,
        ST_REJECT = 2'd3
    } t_status;

    // One registered input transaction.
    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       tx_accept;
        logic [2:0] read_slot;
        logic [8:0] read_offset;
    } t_item;

endpackage

FILE: rtl/psq_slot_mem.sv
`timescale 1ns / 1ps
// Slot byte store: one write port and one registered read port.
// Depends on psq_pkg for nothing but is sized by the top-level parameters.
module psq_slot_mem #(
    parameter int SLOT_COUNT       = 8,
    parameter int MAX_PACKET_BYTES = 512
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_wr_en,
    input  logic [$clog2(SLOT_COUNT)-1:0]           i_wr_slot,
    input  logic [((MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1)-1:0] i_wr_off,
    input  logic [7:0]                              i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [2:0]                              i_rd_slot,
    input  logic [8:0]                              i_rd_offset,
    output logic [7:0]                              o_read_data
);

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int OW    = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
    localparam int AW    = SW + OW;
    localparam int DEPTH = 1 << AW;
    localparam int SXW   = (SW > 3) ? SW : 3;
    localparam int OXW   = (OW > 9) ? OW : 9;

    logic [7:0]     r_mem [DEPTH];
    logic [7:0]     r_rd_data;
    logic           r_rd_ok;
    logic           rd_ok;
    logic [SXW-1:0] rd_slot_x;
    logic [OXW-1:0] rd_off_x;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;

    // Range check of the requested byte; out-of-range reads return zero.
    assign rd_slot_x = SXW'(i_rd_slot);
    assign rd_off_x  = OXW'(i_rd_offset);
    assign rd_ok     = i_rd_en && (32'(i_rd_slot) < SLOT_COUNT)
                       && (32'(i_rd_offset) < MAX_PACKET_BYTES);
    assign rd_addr   = {rd_slot_x[SW-1:0], rd_off_x[OW-1:0]};
    assign wr_addr   = {i_wr_slot, i_wr_off};

    // Byte array, written and read on the clock.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[wr_addr] <= i_wr_data;
        end
        if (rd_ok) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Marks whether the read register holds a valid byte for this result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= rd_ok;
        end
    end

    assign o_read_data = r_rd_ok ? r_rd_data : 8'd0;

endmodule

FILE: rtl/psq_ctrl.sv
`timescale 1ns / 1ps
// Queue control: pointers, packet assembly, submission logic, counters, results.
// Depends on psq_pkg for the transaction struct and the operation and status codes.
module psq_ctrl #(
    parameter int SLOT_COUNT       = 8,
    parameter int MAX_PACKET_BYTES = 512
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_vld,
    input  psq_pkg::t_item                          i_item,
    output logic                                    o_wr_en,
    output logic [$clog2(SLOT_COUNT)-1:0]           o_wr_slot,
    output logic [((MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1)-1:0] o_wr_off,
    output logic [7:0]                              o_wr_data,
    output logic                                    o_strobe,
    output logic [1:0]                              o_status,
    output logic                                    o_tx_start,
    output logic [2:0]                              o_tx_slot,
    output logic [9:0]                              o_tx_length,
    output logic [3:0]                              o_held_packets,
    output logic [31:0]                             o_enqueued_count,
    output logic [31:0]                             o_transmitted_count,
    output logic [31:0]                             o_dropped_count,
    output logic [31:0]                             o_failed_count
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int PW = $clog2(2 * SLOT_COUNT);
    localparam int DW = $clog2(SLOT_COUNT + 1);
    localparam int OW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
    localparam int FW = $clog2(MAX_PACKET_BYTES + 2);
    localparam int LW = $clog2(MAX_PACKET_BYTES + 1);

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_STORE   = 2'd1,
        MODE_DISCARD = 2'd2
    } t_mode;

    // State.
    t_mode          r_mode, n_mode;
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic           r_in_flight, n_in_flight;
    logic [FW-1:0]  r_fill, n_fill;
    logic [31:0]    r_cnt_enq, n_cnt_enq;
    logic [31:0]    r_cnt_tx, n_cnt_tx;
    logic [31:0]    r_cnt_drop, n_cnt_drop;
    logic [31:0]    r_cnt_fail, n_cnt_fail;
    logic [LW-1:0]  r_len [SLOT_COUNT];

    // Result registers.
    logic           r_strobe;
    psq_pkg::t_status r_status, n_status;
    logic           r_tx_start, n_tx_start;
    logic [2:0]     r_tx_slot, n_tx_slot;
    logic [9:0]     r_tx_length, n_tx_length;
    logic [3:0]     r_held_packets, n_held_packets;

    // Intermediate values.
    t_mode          mode_cur;
    logic [FW-1:0]  fill_inc;
    logic           do_enq;
    logic           do_submit;
    logic           in_flight_mid;
    logic           sub_try;
    logic [SW-1:0]  wp_slot;
    logic [SW-1:0]  rp_slot;
    logic [DW-1:0]  depth_now;
    logic [DW-1:0]  depth_new;
    logic [LW-1:0]  len_sel;

    // Pointer advance modulo twice the slot count.
    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PW'(2 * SLOT_COUNT - 1)) ? '0 : p + 1'b1;
    endfunction

    // Packets held between the two pointers.
    function automatic logic [DW-1:0] ring_depth(input logic [PW-1:0] w,
                                                 input logic [PW-1:0] r);
        logic [PW:0] diff;
        if (w >= r) begin
            diff = {1'b0, w} - {1'b0, r};
        end else begin
            diff = {1'b0, w} + (PW + 1)'(2 * SLOT_COUNT) - {1'b0, r};
        end
        return DW'(diff);
    endfunction

    // Slot index of a pointer.
    function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        if (p >= PW'(SLOT_COUNT)) begin
            s = p - PW'(SLOT_COUNT);
        end else begin
            s = p;
        end
        return SW'(s);
    endfunction

    // Next-state and result logic for one transaction.
    always_comb begin
        n_mode        = r_mode;
        n_wp          = r_wp;
        n_rp          = r_rp;
        n_fill        = r_fill;
        n_cnt_enq     = r_cnt_enq;
        n_cnt_tx      = r_cnt_tx;
        n_cnt_drop    = r_cnt_drop;
        n_cnt_fail    = r_cnt_fail;
        n_status      = psq_pkg::ST_NONE;
        do_enq        = 1'b0;
        do_submit     = 1'b0;
        in_flight_mid = r_in_flight;
        o_wr_en       = 1'b0;

        depth_now = ring_depth(r_wp, r_rp);
        wp_slot   = slot_of(r_wp);

        // A packet's mode is settled at its first byte.
        mode_cur = r_mode;
        if (i_item.op == psq_pkg::OP_BYTE && r_mode == MODE_IDLE) begin
            mode_cur = (depth_now >= DW'(SLOT_COUNT)) ? MODE_DISCARD : MODE_STORE;
        end
        fill_inc = (r_fill <= FW'(MAX_PACKET_BYTES)) ? r_fill + 1'b1 : r_fill;

        o_wr_slot = wp_slot;
        o_wr_off  = OW'(r_fill);
        o_wr_data = i_item.data_byte;

        if (i_vld) begin
            unique case (i_item.op)
                psq_pkg::OP_BYTE: begin
                    o_wr_en = (mode_cur == MODE_STORE) && (r_fill < FW'(MAX_PACKET_BYTES));
                    if (i_item.last_byte) begin
                        if (fill_inc > FW'(MAX_PACKET_BYTES)) begin
                            n_status = psq_pkg::ST_REJECT;
                        end else if (mode_cur == MODE_DISCARD) begin
                            n_status   = psq_pkg::ST_DROP;
                            n_cnt_drop = r_cnt_drop + 32'd1;
                        end else begin
                            n_status  = psq_pkg::ST_ENQ;
                            do_enq    = 1'b1;
                            n_wp      = ptr_next(r_wp);
                            n_cnt_enq = r_cnt_enq + 32'd1;
                            do_submit = 1'b1;
                        end
                        n_mode = MODE_IDLE;
                        n_fill = '0;
                    end else begin
                        n_mode = mode_cur;
                        n_fill = fill_inc;
                    end
                end
                psq_pkg::OP_DONE: begin
                    // A completion with nothing in flight is ignored.
                    if (r_in_flight) begin
                        in_flight_mid = 1'b0;
                        n_rp          = ptr_next(r_rp);
                        n_cnt_tx      = r_cnt_tx + 32'd1;
                        do_submit     = 1'b1;
                    end
                end
                psq_pkg::OP_POLL: begin
                    do_submit = 1'b1;
                end
                psq_pkg::OP_READ: begin
                end
                default: begin
                end
            endcase
        end

        // Submission of the oldest slot, seen after this transaction's updates.
        depth_new = ring_depth(n_wp, n_rp);
        rp_slot   = slot_of(n_rp);
        sub_try   = do_submit && !in_flight_mid && (depth_new != '0);
        len_sel   = (do_enq && rp_slot == wp_slot) ? LW'(fill_inc) : r_len[rp_slot];

        n_in_flight = in_flight_mid;
        if (sub_try) begin
            if (i_item.tx_accept) begin
                n_in_flight = 1'b1;
            end else begin
                n_cnt_fail = r_cnt_fail + 32'd1;
            end
        end

        n_tx_start     = sub_try;
        n_tx_slot      = sub_try ? 3'(rp_slot) : 3'd0;
        n_tx_length    = sub_try ? 10'(len_sel) : 10'd0;
        n_held_packets = 4'(depth_new);
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_in_flight <= 1'b0;
            r_fill      <= '0;
            r_cnt_enq   <= '0;
            r_cnt_tx    <= '0;
            r_cnt_drop  <= '0;
            r_cnt_fail  <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= i_vld;
            if (i_vld) begin
                r_mode         <= n_mode;
                r_wp           <= n_wp;
                r_rp           <= n_rp;
                r_in_flight    <= n_in_flight;
                r_fill         <= n_fill;
                r_cnt_enq      <= n_cnt_enq;
                r_cnt_tx       <= n_cnt_tx;
                r_cnt_drop     <= n_cnt_drop;
                r_cnt_fail     <= n_cnt_fail;
                r_status       <= n_status;
                r_tx_start     <= n_tx_start;
                r_tx_slot      <= n_tx_slot;
                r_tx_length    <= n_tx_length;
                r_held_packets <= n_held_packets;
                if (do_enq) begin
                    r_len[wp_slot] <= LW'(fill_inc);
                end
            end
        end
    end

    assign o_strobe            = r_strobe;
    assign o_status            = r_status;
    assign o_tx_start          = r_tx_start;
    assign o_tx_slot           = r_tx_slot;
    assign o_tx_length         = r_tx_length;
    assign o_held_packets      = r_held_packets;
    assign o_enqueued_count    = r_cnt_enq;
    assign o_transmitted_count = r_cnt_tx;
    assign o_dropped_count     = r_cnt_drop;
    assign o_failed_count      = r_cnt_fail;

endmodule

FILE: rtl/packet_slot_ring_transmit_queue_top.sv
`timescale 1ns / 1ps
// Top level of the packet slot ring transmit queue: input register, control, byte store.
// Depends on psq_pkg, psq_ctrl and psq_slot_mem.
//
//   Channel   | Handshake           | Payload
//   ----------+---------------------+----------------------------------------------
//   input     | start, busy         | i_op, i_data_byte, i_last_byte, i_tx_accept,
//             |                     | i_read_slot, i_read_offset
//   result    | o_strobe            | o_status, o_tx_start, o_tx_slot, o_tx_length,
//             |                     | o_read_data, o_held_packets, o_*_count
//
// One transaction is taken every cycle; busy stays low. Each result is registered
// twice after its transaction: first in the input register, then through the control
// logic's result registers and the registered read port of the byte store.
// Reset clears pointers, packet mode, counters and the in-flight flag; the byte
// store and slot lengths are not cleared, so no clearing pass follows reset.
// The receiver cannot stall, so no result is ever held back.
module packet_slot_ring_transmit_queue_top #(
    parameter int SLOT_COUNT       = psq_pkg::DEF_SLOT_COUNT,
    parameter int MAX_PACKET_BYTES = psq_pkg::DEF_MAX_PACKET_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_tx_accept,
    input  logic [2:0]  i_read_slot,
    input  logic [8:0]  i_read_offset,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic        o_tx_start,
    output logic [2:0]  o_tx_slot,
    output logic [9:0]  o_tx_length,
    output logic [7:0]  o_read_data,
    output logic [3:0]  o_held_packets,
    output logic [31:0] o_enqueued_count,
    output logic [31:0] o_transmitted_count,
    output logic [31:0] o_dropped_count,
    output logic [31:0] o_failed_count
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int OW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;

    logic           r_vld;
    psq_pkg::t_item r_item;
    logic           wr_en;
    logic [SW-1:0]  wr_slot;
    logic [OW-1:0]  wr_off;
    logic [7:0]     wr_data;
    logic           rd_en;

    assign busy = 1'b0;

    // Input register: captures each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start && !busy;
            if (start && !busy) begin
                r_item.op          <= psq_pkg::t_op'(i_op);
                r_item.data_byte   <= i_data_byte;
                r_item.last_byte   <= i_last_byte;
                r_item.tx_accept   <= i_tx_accept;
                r_item.read_slot   <= i_read_slot;
                r_item.read_offset <= i_read_offset;
            end
        end
    end

    assign rd_en = r_vld && (r_item.op == psq_pkg::OP_READ);

    psq_ctrl #(
        .SLOT_COUNT       (SLOT_COUNT),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_vld               (r_vld),
        .i_item              (r_item),
        .o_wr_en             (wr_en),
        .o_wr_slot           (wr_slot),
        .o_wr_off            (wr_off),
        .o_wr_data           (wr_data),
        .o_strobe            (o_strobe),
        .o_status            (o_status),
        .o_tx_start          (o_tx_start),
        .o_tx_slot           (o_tx_slot),
        .o_tx_length         (o_tx_length),
        .o_held_packets      (o_held_packets),
        .o_enqueued_count    (o_enqueued_count),
        .o_transmitted_count (o_transmitted_count),
        .o_dropped_count     (o_dropped_count),
        .o_failed_count      (o_failed_count)
    );

    psq_slot_mem #(
        .SLOT_COUNT       (SLOT_COUNT),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_slot_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_slot   (wr_slot),
        .i_wr_off    (wr_off),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_slot   (r_item.read_slot),
        .i_rd_offset (r_item.read_offset),
        .o_read_data (o_read_data)
    );

endmodule

FILE: verif/tb_packet_slot_ring_transmit_queue_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for packet_slot_ring_transmit_queue_top.
// Depends on psq_pkg and the RTL under rtl/. It predicts every result with its own ring model.
module tb_packet_slot_ring_transmit_queue_top;

    localparam int SLOTS        = psq_pkg::DEF_SLOT_COUNT;
    localparam int MAXB         = psq_pkg::DEF_MAX_PACKET_BYTES;
    localparam int PTR_WRAP     = 2 * SLOTS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // Packet assembly mode of the predictor.
    typedef enum bit [1:0] {
        PM_IDLE    = 2'd0,
        PM_STORE   = 2'd1,
        PM_DISCARD = 2'd2
    } t_pkt_mode;

    // One expected result transaction.
    typedef struct packed {
        psq_pkg::t_status status;
        logic        tx_start;
        logic [2:0]  tx_slot;
        logic [9:0]  tx_length;
        logic [7:0]  read_data;
        logic [3:0]  held_packets;
        logic [31:0] enq_count;
        logic [31:0] txd_count;
        logic [31:0] drop_count;
        logic [31:0] fail_count;
    } t_queue_result;

    // Clock, reset and block ports.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic [1:0]  i_op          = '0;
    logic [7:0]  i_data_byte   = '0;
    logic        i_last_byte   = 1'b0;
    logic        i_tx_accept   = 1'b0;
    logic [2:0]  i_read_slot   = '0;
    logic [8:0]  i_read_offset = '0;
    logic        busy;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic        o_tx_start;
    logic [2:0]  o_tx_slot;
    logic [9:0]  o_tx_length;
    logic [7:0]  o_read_data;
    logic [3:0]  o_held_packets;
    logic [31:0] o_enqueued_count;
    logic [31:0] o_transmitted_count;
    logic [31:0] o_dropped_count;
    logic [31:0] o_failed_count;

    packet_slot_ring_transmit_queue_top uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_op                (i_op),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .i_tx_accept         (i_tx_accept),
        .i_read_slot         (i_read_slot),
        .i_read_offset       (i_read_offset),
        .o_strobe            (o_strobe),
        .o_status            (o_status),
        .o_tx_start          (o_tx_start),
        .o_tx_slot           (o_tx_slot),
        .o_tx_length         (o_tx_length),
        .o_read_data         (o_read_data),
        .o_held_packets      (o_held_packets),
        .o_enqueued_count    (o_enqueued_count),
        .o_transmitted_count (o_transmitted_count),
        .o_dropped_count     (o_dropped_count),
        .o_failed_count      (o_failed_count)
    );

    // Free-running clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ring predictor state. Bytes of a slot are always written from offset 0 upward,
    // so slot_fill_mark holds how many leading bytes of each slot hold known data.
    logic [7:0]  slot_store [SLOTS * MAXB];
    int          slot_fill_mark [SLOTS];
    logic [9:0]  slot_len [SLOTS];
    int unsigned wr_ptr     = 0;
    int unsigned rd_ptr     = 0;
    int unsigned fill_count = 0;
    bit          tx_pending = 1'b0;
    t_pkt_mode   pkt_mode   = PM_IDLE;
    logic [31:0] n_enq      = '0;
    logic [31:0] n_txd      = '0;
    logic [31:0] n_drop     = '0;
    logic [31:0] n_fail     = '0;

    // Run bookkeeping.
    t_queue_result pending_results [$];
    int sender_idle_pct = 0;
    int sent_count      = 0;
    int checked_count   = 0;
    int reject_count    = 0;
    int err_count       = 0;
    int cycle_count     = 0;

    function automatic int unsigned ring_depth();
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + PTR_WRAP - rd_ptr;
    endfunction

    function automatic int unsigned bump_ptr(input int unsigned p);
        return (p + 1 >= PTR_WRAP) ? 0 : p + 1;
    endfunction

    // Offer the oldest queued slot to the transmitter when nothing is in flight.
    function automatic void try_submit(input logic accept, inout t_queue_result r);
        int unsigned s;
        if (tx_pending || ring_depth() == 0)
            return;
        s = rd_ptr % SLOTS;
        r.tx_start  = 1'b1;
        r.tx_slot   = 3'(s);
        r.tx_length = slot_len[s];
        if (accept)
            tx_pending = 1'b1;
        else
            n_fail++;
    endfunction

    // Advance the predictor by one accepted transaction and return its result.
    function automatic t_queue_result predict_transaction(input psq_pkg::t_item it);
        t_queue_result r;
        int unsigned   s;
        r = '0;
        case (it.op)
            psq_pkg::OP_BYTE: begin
                // Fullness is decided once, at the first byte of a packet.
                if (pkt_mode == PM_IDLE)
                    pkt_mode = (ring_depth() >= SLOTS) ? PM_DISCARD : PM_STORE;
                s = wr_ptr % SLOTS;
                if (pkt_mode == PM_STORE && fill_count < MAXB) begin
                    slot_store[s * MAXB + fill_count] = it.data_byte;
                    if (fill_count >= slot_fill_mark[s])
                        slot_fill_mark[s] = fill_count + 1;
                end
                if (fill_count <= MAXB)
                    fill_count++;
                if (it.last_byte) begin
                    // An oversize packet is rejected even when the ring was full.
                    if (fill_count > MAXB) begin
                        r.status = psq_pkg::ST_REJECT;
                        reject_count++;
                    end else if (pkt_mode == PM_DISCARD) begin
                        r.status = psq_pkg::ST_DROP;
                        n_drop++;
                    end else begin
                        slot_len[s] = 10'(fill_count);
                        wr_ptr      = bump_ptr(wr_ptr);
                        n_enq++;
                        r.status    = psq_pkg::ST_ENQ;
                        try_submit(it.tx_accept, r);
                    end
                    pkt_mode   = PM_IDLE;
                    fill_count = 0;
                end
            end
            psq_pkg::OP_DONE: begin
                // A completion with nothing in flight changes nothing.
                if (tx_pending) begin
                    tx_pending = 1'b0;
                    rd_ptr     = bump_ptr(rd_ptr);
                    n_txd++;
                    try_submit(it.tx_accept, r);
                end
            end
            psq_pkg::OP_POLL: begin
                try_submit(it.tx_accept, r);
            end
            default: begin
                if (it.read_slot < SLOTS && it.read_offset < MAXB)
                    r.read_data = slot_store[it.read_slot * MAXB + it.read_offset];
            end
        endcase
        r.held_packets = 4'(ring_depth());
        r.enq_count    = n_enq;
        r.txd_count    = n_txd;
        r.drop_count   = n_drop;
        r.fail_count   = n_fail;
        return r;
    endfunction

    // Present one transaction, wait until the block takes it, then predict its result.
    task automatic send_transaction(input psq_pkg::t_op op, input logic [7:0] data,
                                    input logic is_last, input logic accept,
                                    input logic [2:0] rslot, input logic [8:0] roff);
        psq_pkg::t_item it;
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        it.op          = op;
        it.data_byte   = data;
        it.last_byte   = is_last;
        it.tx_accept   = accept;
        it.read_slot   = rslot;
        it.read_offset = roff;
        start         <= 1'b1;
        i_op          <= it.op;
        i_data_byte   <= it.data_byte;
        i_last_byte   <= it.last_byte;
        i_tx_accept   <= it.tx_accept;
        i_read_slot   <= it.read_slot;
        i_read_offset <= it.read_offset;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_transaction(it));
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] data, input logic is_last, input logic accept);
        send_transaction(psq_pkg::OP_BYTE, data, is_last, accept,
                         3'($urandom_range(7)), 9'($urandom_range(511)));
    endtask

    // Completion or poll; the byte and read fields are don't-care here.
    task automatic send_op(input psq_pkg::t_op op, input logic accept);
        send_transaction(op, 8'($urandom_range(255)), 1'($urandom_range(1)), accept,
                         3'($urandom_range(7)), 9'($urandom_range(511)));
    endtask

    task automatic send_read(input logic [2:0] rslot, input logic [8:0] roff);
        send_transaction(psq_pkg::OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), rslot, roff);
    endtask

    // Whole packet of random content; only the last byte's accept flag matters.
    task automatic send_packet(input int len, input logic accept);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1,
                      (i == len - 1) ? accept : 1'($urandom_range(1)));
    endtask

    // Report a failure; only the first few are printed.
    function automatic void report_error(input string msg);
        err_count++;
        if (err_count <= REPORT_LIMIT)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v)
            report_error($sformatf("%s expected 0x%0h, got 0x%0h", name, exp_v, act_v));
    endfunction

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_error("result with no transaction outstanding");
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                check_field("status", want.status, o_status);
                check_field("tx_start", want.tx_start, o_tx_start);
                check_field("tx_slot", want.tx_slot, o_tx_slot);
                check_field("tx_length", want.tx_length, o_tx_length);
                check_field("read_data", want.read_data, o_read_data);
                check_field("held_packets", want.held_packets, o_held_packets);
                check_field("enqueued_count", want.enq_count, o_enqueued_count);
                check_field("transmitted_count", want.txd_count, o_transmitted_count);
                check_field("dropped_count", want.drop_count, o_dropped_count);
                check_field("failed_count", want.fail_count, o_failed_count);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("packet_slot_ring_transmit_queue_top regression: fail");
            $finish;
        end
    end

    // Empty ring: stray completion and polls have nothing to submit.
    task automatic test_empty_ring();
        send_op(psq_pkg::OP_DONE, 1'b1);
        send_op(psq_pkg::OP_POLL, 1'b1);
        send_op(psq_pkg::OP_POLL, 1'b0);
    endtask

    // Refused and accepted submissions, reads of stored bytes, completions.
    task automatic test_submit_and_complete();
        send_byte(8'hFF, 1'b1, 1'b0);
        send_op(psq_pkg::OP_POLL, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b1);
        send_byte(8'h5A, 1'b1, 1'b1);
        send_read(3'd0, 9'd0);
        send_read(3'd1, 9'd2);
        send_op(psq_pkg::OP_DONE, 1'b0);
        send_op(psq_pkg::OP_DONE, 1'b1);
        send_op(psq_pkg::OP_POLL, 1'b1);
        send_op(psq_pkg::OP_DONE, 1'b1);
    endtask

    // Fill every slot with the transmitter refusing, then lose one packet.
    task automatic test_ring_full_drop();
        repeat (SLOTS) send_byte(8'($urandom_range(255)), 1'b1, 1'b0);
        send_packet(2, 1'b1);
    endtask

    // Oversize packet while full is rejected, not dropped; then drain the ring.
    task automatic test_reject_precedence();
        send_packet(MAXB + 3, 1'b1);
        send_op(psq_pkg::OP_POLL, 1'b1);
        repeat (SLOTS) send_op(psq_pkg::OP_DONE, 1'b1);
    endtask

    // Largest packet, then an oversize one whose first bytes still land in a slot.
    task automatic test_longest_packets();
        int s;
        s = wr_ptr % SLOTS;
        send_packet(MAXB, 1'b1);
        send_read(3'(s), 9'(MAXB - 1));
        send_read(3'(s), 9'd0);
        send_read(3'(s), 9'h155);
        send_op(psq_pkg::OP_DONE, 1'b1);
        s = wr_ptr % SLOTS;
        send_packet(MAXB + 1, 1'b1);
        send_read(3'(s), 9'(MAXB - 1));
        send_read(3'(s), 9'h0AA);
    endtask

    // Short packets with random content interleaved with completions, polls and reads.
    task automatic test_random_traffic(input int n, input int accept_pct, input int done_pct);
        int open_left;
        int sel;
        int s;
        int marks [$];
        logic acc;
        open_left = 0;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            acc = ($urandom_range(99) < accept_pct);
            if (sel < 50) begin
                if (open_left == 0)
                    open_left = ($urandom_range(9) == 0) ? $urandom_range(40, 17)
                                                         : $urandom_range(8, 1);
                send_byte(8'($urandom_range(255)), open_left == 1, acc);
                open_left--;
            end else if (sel < 50 + done_pct) begin
                send_op(psq_pkg::OP_DONE, acc);
            end else if (sel < 60 + done_pct) begin
                send_op(psq_pkg::OP_POLL, acc);
            end else begin
                // Reads only touch bytes that some packet has written.
                marks.delete();
                foreach (slot_fill_mark[i])
                    if (slot_fill_mark[i] > 0)
                        marks.push_back(i);
                if (marks.size() == 0) begin
                    send_op(psq_pkg::OP_POLL, acc);
                end else begin
                    s = marks[$urandom_range(marks.size() - 1)];
                    send_read(3'(s), 9'($urandom_range(slot_fill_mark[s] - 1)));
                end
            end
        end
        while (open_left > 0) begin
            send_byte(8'($urandom_range(255)), open_left == 1,
                      ($urandom_range(99) < accept_pct));
            open_left--;
        end
    endtask

    // Test sequence.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 22;
        test_empty_ring();
        test_submit_and_complete();
        test_ring_full_drop();
        test_reject_precedence();
        test_longest_packets();
        test_random_traffic(50, 70, 25);

        sender_idle_pct = 51;
        test_random_traffic(40, 50, 8);

        sender_idle_pct = 0;
        test_random_traffic(40, 85, 30);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions and checked %0d results in %0d cycles.",
                 sent_count, checked_count, cycle_count);
        $display("Packets: %0d enqueued, %0d transmitted, %0d dropped, %0d rejected, %0d refused.",
                 n_enq, n_txd, n_drop, reject_count, n_fail);
        if (err_count == 0) begin
            $display("packet_slot_ring_transmit_queue_top regression: pass");
        end else begin
            $display("%0d errors found", err_count);
            $display("packet_slot_ring_transmit_queue_top regression: fail");
        end
        $finish;
    end

endmodule
